// ===== rtl/smf_pkg.sv =====
package smf_pkg;

  // Pattern register file holds sixteen bytes whatever the window depth
  localparam int unsigned PatternBytes = 16;
  localparam int unsigned PatIdxW      = 4;

  // Result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam int unsigned TotalW = 16;
  localparam int unsigned StartW = 16;

  // Configuration register indexes
  localparam logic [1:0] CfgPatLow  = 2'd0;
  localparam logic [1:0] CfgPatHigh = 2'd1;
  localparam logic [1:0] CfgPatLen  = 2'd2;

  typedef struct packed {
    logic              is_match;
    logic [StartW-1:0] start_position;
    logic [TotalW-1:0] match_total;
    logic              final_result;
  } smf_result_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } smf_push_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic check;
  } smf_cell_ctrl_t;

endpackage

// ===== rtl/smf_cell.sv =====
module smf_cell
  import smf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  smf_cell_ctrl_t ctrl_i,
  input  logic [7:0]     byte_i,
  input  logic [7:0]     expected_i,
  output logic [7:0]     byte_o,
  output logic           eq_o
);

  logic [7:0] byte_q, byte_d;

  // Compare the byte that lands in this cell with this request
  assign eq_o   = !ctrl_i.check || (byte_i == expected_i);
  assign byte_o = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== rtl/smf_queue.sv =====
module smf_queue
  import smf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  smf_push_t   push_i,
  input  smf_result_t data_a_i,
  input  smf_result_t data_b_i,
  output logic        room_o,
  output logic        valid_o,
  input  logic        ready_i,
  output smf_result_t data_o
);

  smf_result_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 pop;
  logic [QueuePtrW-1:0] wp_next;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  // Two free entries are needed for a match and a summary from one request
  assign room_o  = (cnt_q <= QueueCntW'(QueueDepth - 2));
  assign wp_next = wp_q + QueuePtrW'(1);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i.push_a && push_i.push_b) begin
      wp_d  = wp_q + QueuePtrW'(2);
      cnt_d = cnt_d + QueueCntW'(2);
    end else if (push_i.push_a) begin
      wp_d  = wp_next;
      cnt_d = cnt_d + QueueCntW'(1);
    end
    if (pop) begin
      rp_d  = rp_q + QueuePtrW'(1);
      cnt_d = cnt_d - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wp_q] <= data_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wp_next] <= data_b_i;
    end
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("result queue level beyond depth");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_b |-> push_i.push_a)
    else $error("second result pushed without first");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_a |-> cnt_q <= QueueCntW'(QueueDepth - 2))
    else $error("result pushed into full queue");
`endif

endmodule

// ===== rtl/substring_match_finder.sv =====
// Channel   Direction  Handshake                  Payload
// in        in         in_valid_i / in_ready_o    text_byte_i, end_of_text_i
// out       out        out_valid_o / out_ready_i  is_match_o, start_position_o,
//                                                 match_total_o, final_result_o
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One text byte is taken per cycle while two queue entries are free; the shift chain
// of window cells and the pattern compare complete in the cycle the byte is taken.
// Results enter a four-entry queue and leave it in order under the output handshake.
// Input is held off only while fewer than two queue entries are free.
// Reset clears the window, counters, pattern registers (length one) and queue.
// The configuration port is always ready.
module substring_match_finder
  import smf_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned POSITION_BITS     = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              text_byte_i,
  input  logic                    end_of_text_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    is_match_o,
  output logic [StartW-1:0]       start_position_o,
  output logic [TotalW-1:0]       match_total_o,
  output logic                    final_result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [63:0]             cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PATTERN_BYTES);
  localparam logic [4:0] LenMax = 5'(MAX_PATTERN_BYTES);

  logic [63:0] pat_low_q, pat_high_q;
  logic [4:0]  pat_len_q;
  logic [7:0]  pat_bytes [PatternBytes];
  logic [CntW-1:0] len_eff;

  logic [CntW-1:0]          seen_q, seen_d, since_q, since_d;
  logic [CntW-1:0]          seen_inc, since_inc;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [TotalW-1:0]        cnt_q, cnt_d, cnt_new;

  logic           accept, hit;
  logic [7:0]     chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] eq;
  smf_cell_ctrl_t cell_ctrl [MAX_PATTERN_BYTES];
  logic [31:0]    start_full;

  smf_push_t   push;
  smf_result_t res_a, res_b, res_out;
  logic        room;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  for (genvar p = 0; p < PatternBytes; p++) begin : g_pat
    if (p < 8) begin : g_low
      assign pat_bytes[p] = pat_low_q[8*p +: 8];
    end else begin : g_high
      assign pat_bytes[p] = pat_high_q[8*(p-8) +: 8];
    end
  end

  // Clamp the length into one to window depth
  always_comb begin
    if (pat_len_q == 5'd0) begin
      len_eff = CntW'(1);
    end else if (pat_len_q > LenMax) begin
      len_eff = CntMax;
    end else begin
      len_eff = CntW'(pat_len_q);
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = room;

  // Window: cell k receives the byte taken k requests ago and checks it against
  // pattern byte len-1-k
  assign chain[0] = text_byte_i;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [CntW-1:0] diff;
    logic [7:0]      expected;

    assign diff     = len_eff - CntW'(k + 1);
    assign expected = pat_bytes[PatIdxW'(diff)];

    assign cell_ctrl[k].shift = accept;
    assign cell_ctrl[k].clear = accept && end_of_text_i;
    assign cell_ctrl[k].check = (CntW'(k) < len_eff);

    smf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[k]),
      .byte_i     (chain[k]),
      .expected_i (expected),
      .byte_o     (chain[k+1]),
      .eq_o       (eq[k])
    );
  end

  assign seen_inc  = (seen_q < CntMax) ? seen_q + CntW'(1) : seen_q;
  assign since_inc = (since_q < CntMax) ? since_q + CntW'(1) : since_q;

  assign hit = (seen_inc >= len_eff) && (since_inc >= len_eff) && (&eq);

  assign cnt_new = (hit && (cnt_q != '1)) ? cnt_q + TotalW'(1) : cnt_q;

  assign start_full = 32'(pos_q) - 32'(len_eff) + 32'd1;

  always_comb begin
    seen_d  = seen_q;
    since_d = since_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (end_of_text_i) begin
        seen_d  = '0;
        since_d = CntMax;
        pos_d   = '0;
        cnt_d   = '0;
      end else begin
        seen_d  = seen_inc;
        since_d = hit ? '0 : since_inc;
        pos_d   = (pos_q != '1) ? pos_q + POSITION_BITS'(1) : pos_q;
        cnt_d   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      since_q <= CntMax;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      seen_q  <= seen_d;
      since_q <= since_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // The summary goes first when there is no match alongside it
  always_comb begin
    res_b.is_match       = 1'b0;
    res_b.start_position = '0;
    res_b.match_total    = cnt_new;
    res_b.final_result   = 1'b1;
    if (hit) begin
      res_a.is_match       = 1'b1;
      res_a.start_position = start_full[StartW-1:0];
      res_a.match_total    = cnt_new;
      res_a.final_result   = 1'b0;
    end else begin
      res_a = res_b;
    end
  end

  assign push.push_a = accept && (hit || end_of_text_i);
  assign push.push_b = accept && hit && end_of_text_i;

  smf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i (res_a),
    .data_b_i (res_b),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (res_out)
  );

  assign is_match_o       = res_out.is_match;
  assign start_position_o = res_out.start_position;
  assign match_total_o    = res_out.match_total;
  assign final_result_o   = res_out.final_result;

`ifndef SYNTH
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |=> (seen_q == '0) && (cnt_q == '0) && (pos_q == '0))
    else $error("text state not cleared after end of text");

  a_match_restarts_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hit && !end_of_text_i) |=> (since_q == '0))
    else $error("match distance not restarted");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pos_q == '1) && !(accept && end_of_text_i)) |=> (pos_q == '1))
    else $error("byte position left saturation");
`endif

endmodule
